[hw/rtl/look_at_view_matrix_defines.svh]
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LAV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define LAV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg
// widths, state types and arithmetic helpers shared by the look-at matrix
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int unsigned Q_W    = 32;  // Q16.16 word
  localparam int unsigned FWD_W  = 33;  // target - eye
  localparam int unsigned UNIT_W = 18;  // signed unit component
  localparam int unsigned SIDE_W = 51;  // full precision z cross up
  localparam int unsigned M_W    = 30;  // normalized magnitude
  localparam int unsigned Y_W    = 19;  // rounded x cross z
  localparam int unsigned SUM_W  = 48;  // rounded dot product
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned QUO_W  = 18;
  localparam int unsigned DREM_W = 32;

  localparam logic [Q_W-1:0] Q_ONE    = 32'h0001_0000;
  localparam logic [1:0]     ROW_LAST = 2'd3;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  nl;
    logic [QUO_W-1:0]  quo;
  } div_t;

  // one digit of the restoring integer square root
  function automatic sqrt_t sqrt_step(sqrt_t a, logic [1:0] bits);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    sqrt_t o;
    r = {a.rem[REM_W-3:0], bits};
    t = {2'b00, a.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of the restoring division
  function automatic div_t div_step(div_t a, logic [LEN_W-1:0] d);
    logic [DREM_W-1:0] r;
    div_t o;
    r    = {a.rem[DREM_W-2:0], a.nl[QUO_W-1]};
    o.nl = {a.nl[QUO_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      o.rem = r - {1'b0, d};
      o.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // position of the highest set bit of a byte
  function automatic logic [2:0] msb8(logic [7:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  // back to Q16.16, round half up
  function automatic logic signed [SUM_W-1:0] round_q16(logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return SUM_W'(t >>> 16);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic [Q_W-1:0] sat_q16(logic signed [SUM_W-1:0] v);
    logic [SUM_W-Q_W:0] hi;
    logic [Q_W-1:0] r;
    hi = v[SUM_W-1:Q_W-1];
    if (&hi || !(|hi)) r = v[Q_W-1:0];
    else if (v[SUM_W-1]) r = 32'h8000_0000;
    else r = 32'h7fff_ffff;
    return r;
  endfunction

endpackage

[hw/rtl/lav_in_if.sv]
// ----------------------------------------------------------------------------
// lav_in_if
// input channel: eye, target and up vectors with valid/ready
// ----------------------------------------------------------------------------
interface lav_in_if;
  import lav_pkg::*;

  logic valid;
  logic ready;
  logic signed [Q_W-1:0] eye_x;
  logic signed [Q_W-1:0] eye_y;
  logic signed [Q_W-1:0] eye_z;
  logic signed [Q_W-1:0] target_x;
  logic signed [Q_W-1:0] target_y;
  logic signed [Q_W-1:0] target_z;
  logic signed [Q_W-1:0] up_x;
  logic signed [Q_W-1:0] up_y;
  logic signed [Q_W-1:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

[hw/rtl/lav_out_if.sv]
// ----------------------------------------------------------------------------
// lav_out_if
// output channel: one view matrix row per word with valid/ready
// ----------------------------------------------------------------------------
interface lav_out_if;
  import lav_pkg::*;

  logic valid;
  logic ready;
  logic [1:0] row_index;
  logic signed [Q_W-1:0] entry_col0;
  logic signed [Q_W-1:0] entry_col1;
  logic signed [Q_W-1:0] entry_col2;
  logic signed [Q_W-1:0] entry_col3;
  logic last_row;
  logic degenerate;

  modport source (output valid, row_index, entry_col0, entry_col1, entry_col2,
                  entry_col3, last_row, degenerate, input ready);
  modport sink (input valid, row_index, entry_col0, entry_col1, entry_col2,
                entry_col3, last_row, degenerate, output ready);
endinterface

[hw/rtl/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm
// pipelined 3-vector normalizer: block scaling, pipelined square root and
// three pipelined dividers, sideband carried alongside, 22 stages
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int unsigned IW = lav_pkg::FWD_W,
  parameter int unsigned SW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [2:0][IW-1:0]               vec_i,
  input  logic [SW-1:0]                    side_i,
  output logic                             valid_o,
  output logic [2:0][lav_pkg::UNIT_W-1:0]  unit_o,
  output logic                             zero_o,
  output logic [SW-1:0]                    side_o
);
  import lav_pkg::*;

  localparam int unsigned NG       = (IW + 7) / 8;
  localparam int unsigned PW       = $clog2(NG * 8);
  localparam int unsigned CB_W     = SW + 4;
  localparam int unsigned NSQ      = 8;
  localparam int unsigned SQ_STEPS = ROOT_W / NSQ;
  localparam int unsigned NDV      = 6;
  localparam int unsigned DV_STEPS = QUO_W / NDV;
  localparam int unsigned NUM_W    = M_W + 17;
  localparam logic [PW-1:0] TOP_POS = PW'(M_W - 1);

  // stage 1: magnitudes, signs, or of magnitudes
  logic              v1_q;
  logic [2:0][IW-1:0] mag1_q;
  logic [2:0]        sgn1_q;
  logic [IW-1:0]     or1_q;
  logic [SW-1:0]     side1_q;
  logic [2:0][IW-1:0] mag_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = vec_i[k][IW-1] ? IW'(-vec_i[k]) : vec_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      sgn1_q  <= {vec_i[2][IW-1], vec_i[1][IW-1], vec_i[0][IW-1]};
      or1_q   <= mag_d[0] | mag_d[1] | mag_d[2];
      side1_q <= side_i;
    end
  end

  // stage 2: leading one per byte
  logic              v2_q;
  logic [2:0][IW-1:0] mag2_q;
  logic [2:0]        sgn2_q;
  logic [SW-1:0]     side2_q;
  logic [NG-1:0]     gnz2_q;
  logic [NG-1:0][2:0] glo2_q;
  logic [NG*8-1:0]   orp;

  assign orp = (NG*8)'(or1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag1_q;
      sgn2_q  <= sgn1_q;
      side2_q <= side1_q;
      for (int g = 0; g < NG; g++) begin
        gnz2_q[g] <= |orp[g*8 +: 8];
        glo2_q[g] <= msb8(orp[g*8 +: 8]);
      end
    end
  end

  // stage 3: leading one of the whole word
  logic              v3_q;
  logic [2:0][IW-1:0] mag3_q;
  logic [2:0]        sgn3_q;
  logic [SW-1:0]     side3_q;
  logic [PW-1:0]     pos3_q;
  logic              zero3_q;
  logic [PW-1:0]     pos_d;

  always_comb begin
    pos_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz2_q[g]) pos_d = PW'(g * 8) + PW'(glo2_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      side3_q <= side2_q;
      pos3_q  <= pos_d;
      zero3_q <= ~|gnz2_q;
    end
  end

  // stage 4: common shift so the largest magnitude sits in [2^29, 2^30)
  logic               v4_q;
  logic [2:0][M_W-1:0] m4_q;
  logic [CB_W-1:0]    cb4_q;
  logic [2:0][M_W-1:0] m_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos3_q >= TOP_POS) m_d[k] = M_W'(mag3_q[k] >> (pos3_q - TOP_POS));
      else m_d[k] = mag3_q[k][M_W-1:0] << (TOP_POS - pos3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en_i) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q  <= m_d;
      cb4_q <= {side3_q, sgn3_q, zero3_q};
    end
  end

  // stage 5: squares
  logic                  v5_q;
  logic [2:0][M_W-1:0]   m5_q;
  logic [CB_W-1:0]       cb5_q;
  logic [2:0][2*M_W-1:0] sq5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en_i) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m5_q  <= m4_q;
      cb5_q <= cb4_q;
      for (int k = 0; k < 3; k++) begin
        sq5_q[k] <= (2*M_W)'(m4_q[k]) * (2*M_W)'(m4_q[k]);
      end
    end
  end

  // stage 6 and square root stages: four root digits per stage
  logic                vs_q  [NSQ+1];
  sqrt_t               st_q  [NSQ+1];
  logic [63:0]         nn_q  [NSQ+1];
  logic [2:0][M_W-1:0] ms_q  [NSQ+1];
  logic [CB_W-1:0]     cbs_q [NSQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q[0] <= 1'b0;
    else if (en_i) vs_q[0] <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= '0;
      nn_q[0]  <= 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
      ms_q[0]  <= m5_q;
      cbs_q[0] <= cb5_q;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    sqrt_t st_d;

    always_comb begin
      st_d = st_q[k];
      for (int j = 0; j < SQ_STEPS; j++) begin
        st_d = sqrt_step(st_d, nn_q[k][63 - 2*(SQ_STEPS*k + j) -: 2]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[k+1] <= 1'b0;
      else if (en_i) vs_q[k+1] <= vs_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1]  <= st_d;
        nn_q[k+1]  <= nn_q[k];
        ms_q[k+1]  <= ms_q[k];
        cbs_q[k+1] <= cbs_q[k];
      end
    end
  end

  // stage 7 and divider stages: rounded numerator, three quotient bits per stage
  logic             vd_q  [NDV+1];
  div_t             dv_q  [NDV+1][3];
  logic [LEN_W-1:0] len_q [NDV+1];
  logic [CB_W-1:0]  cbd_q [NDV+1];
  logic [LEN_W-1:0] len_d;
  logic [2:0][NUM_W-1:0] num_d;

  assign len_d = st_q[NSQ].root[LEN_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = {1'b0, ms_q[NSQ][k], 16'h0000} + NUM_W'(len_d >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q[0] <= 1'b0;
    else if (en_i) vd_q[0] <= vs_q[NSQ];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0] <= len_d;
      cbd_q[0] <= cbs_q[NSQ];
      for (int k = 0; k < 3; k++) begin
        dv_q[0][k].rem <= DREM_W'(num_d[k][NUM_W-1:QUO_W]);
        dv_q[0][k].nl  <= num_d[k][QUO_W-1:0];
        dv_q[0][k].quo <= '0;
      end
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    div_t dv_d [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        dv_d[c] = dv_q[k][c];
        for (int j = 0; j < DV_STEPS; j++) begin
          dv_d[c] = div_step(dv_d[c], len_q[k]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[k+1] <= 1'b0;
      else if (en_i) vd_q[k+1] <= vd_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k+1] <= len_q[k];
        cbd_q[k+1] <= cbd_q[k];
        for (int c = 0; c < 3; c++) begin
          dv_q[k+1][c] <= dv_d[c];
        end
      end
    end
  end

  // stage 8: apply signs
  logic                   v8_q;
  logic [2:0][UNIT_W-1:0] u8_q;
  logic                   zero8_q;
  logic [SW-1:0]          side8_q;
  logic [CB_W-1:0]        cb_fin;

  assign cb_fin = cbd_q[NDV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en_i) v8_q <= vd_q[NDV];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        u8_q[k] <= cb_fin[k+1] ? UNIT_W'(-dv_q[NDV][k].quo) : dv_q[NDV][k].quo;
      end
      zero8_q <= cb_fin[0];
      side8_q <= cb_fin[CB_W-1:4];
    end
  end

  assign valid_o = v8_q;
  assign unit_o  = u8_q;
  assign zero_o  = zero8_q;
  assign side_o  = side8_q;

endmodule

[hw/rtl/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix
// right-handed look-at view matrix in Q16.16, four rows per input word
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_i     in   eye, target, up: nine signed Q16.16 values
// out_o    out  row_index, entry_col0..3, last_row, degenerate
//
// the four rows of a word share the output channel: the next word loads
// once the last row is taken or the serializer is idle; the first row is
// valid past the pipeline below, rows follow each cycle out_o is ready
// the pipeline is an input stage, two normalizers of 22 stages each, five
// stages of cross and dot products and the row register
// reset clears every valid bit and the row serializer
// a stall on out_o freezes the whole pipeline once its last stage is full
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix (
  input logic         clk_i,
  input logic         rst_ni,
  lav_in_if.sink      in_i,
  lav_out_if.source   out_o
);
  import lav_pkg::*;

  localparam int unsigned SA_W = 6 * Q_W;
  localparam int unsigned SB_W = 3 * Q_W + 3 * UNIT_W + 1;

  logic en;
  logic load;

  // stage t1: forward vector
  logic                 t1_v_q;
  logic [2:0][FWD_W-1:0] t1_fwd_q;
  logic [2:0][Q_W-1:0]  t1_eye_q;
  logic [2:0][Q_W-1:0]  t1_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_v_q <= 1'b0;
    else if (en) t1_v_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_fwd_q[0] <= FWD_W'(in_i.target_x) - FWD_W'(in_i.eye_x);
      t1_fwd_q[1] <= FWD_W'(in_i.target_y) - FWD_W'(in_i.eye_y);
      t1_fwd_q[2] <= FWD_W'(in_i.target_z) - FWD_W'(in_i.eye_z);
      t1_eye_q    <= {in_i.eye_z, in_i.eye_y, in_i.eye_x};
      t1_up_q     <= {in_i.up_z, in_i.up_y, in_i.up_x};
    end
  end

  assign in_i.ready = en;

  // forward normalizer
  logic                   a_v;
  logic [2:0][UNIT_W-1:0] a_z;
  logic                   a_zero;
  logic [SA_W-1:0]        a_side;
  logic [2:0][Q_W-1:0]    a_eye;
  logic [2:0][Q_W-1:0]    a_up;

  lav_norm #(
    .IW (FWD_W),
    .SW (SA_W)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t1_v_q),
    .vec_i   (t1_fwd_q),
    .side_i  ({t1_eye_q, t1_up_q}),
    .valid_o (a_v),
    .unit_o  (a_z),
    .zero_o  (a_zero),
    .side_o  (a_side)
  );

  assign a_eye = a_side[SA_W-1:3*Q_W];
  assign a_up  = a_side[3*Q_W-1:0];

  // stage t2: products of z cross up
  logic                   t2_v_q;
  logic signed [UNIT_W+Q_W-1:0] t2_p_q [6];
  logic [2:0][Q_W-1:0]    t2_eye_q;
  logic [2:0][UNIT_W-1:0] t2_z_q;
  logic                   t2_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t2_v_q <= 1'b0;
    else if (en) t2_v_q <= a_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_p_q[0] <= $signed(a_z[1]) * $signed(a_up[2]);
      t2_p_q[1] <= $signed(a_z[2]) * $signed(a_up[1]);
      t2_p_q[2] <= $signed(a_z[2]) * $signed(a_up[0]);
      t2_p_q[3] <= $signed(a_z[0]) * $signed(a_up[2]);
      t2_p_q[4] <= $signed(a_z[0]) * $signed(a_up[1]);
      t2_p_q[5] <= $signed(a_z[1]) * $signed(a_up[0]);
      t2_eye_q  <= a_eye;
      t2_z_q    <= a_z;
      t2_zero_q <= a_zero;
    end
  end

  // stage t3: side vector at full precision
  logic                    t3_v_q;
  logic [2:0][SIDE_W-1:0]  t3_side_q;
  logic [2:0][Q_W-1:0]     t3_eye_q;
  logic [2:0][UNIT_W-1:0]  t3_z_q;
  logic                    t3_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t3_v_q <= 1'b0;
    else if (en) t3_v_q <= t2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_side_q[0] <= SIDE_W'(t2_p_q[0]) - SIDE_W'(t2_p_q[1]);
      t3_side_q[1] <= SIDE_W'(t2_p_q[2]) - SIDE_W'(t2_p_q[3]);
      t3_side_q[2] <= SIDE_W'(t2_p_q[4]) - SIDE_W'(t2_p_q[5]);
      t3_eye_q     <= t2_eye_q;
      t3_z_q       <= t2_z_q;
      t3_zero_q    <= t2_zero_q;
    end
  end

  // side normalizer
  logic                   b_v;
  logic [2:0][UNIT_W-1:0] b_x;
  logic                   b_zero;
  logic [SB_W-1:0]        b_side;
  logic [2:0][Q_W-1:0]    b_eye;
  logic [2:0][UNIT_W-1:0] b_z;
  logic                   b_zero_fwd;

  lav_norm #(
    .IW (SIDE_W),
    .SW (SB_W)
  ) u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t3_v_q),
    .vec_i   (t3_side_q),
    .side_i  ({t3_eye_q, t3_z_q, t3_zero_q}),
    .valid_o (b_v),
    .unit_o  (b_x),
    .zero_o  (b_zero),
    .side_o  (b_side)
  );

  assign b_eye      = b_side[SB_W-1:3*UNIT_W+1];
  assign b_z        = b_side[3*UNIT_W:1];
  assign b_zero_fwd = b_side[0];

  // stage t4: products of x cross z and of x, z with eye
  logic                          t4_v_q;
  logic signed [2*UNIT_W-1:0]    t4_xz_q [6];
  logic signed [UNIT_W+Q_W-1:0]  t4_xe_q [3];
  logic signed [UNIT_W+Q_W-1:0]  t4_ze_q [3];
  logic [2:0][UNIT_W-1:0]        t4_x_q;
  logic [2:0][UNIT_W-1:0]        t4_z_q;
  logic [2:0][Q_W-1:0]           t4_eye_q;
  logic                          t4_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t4_v_q <= 1'b0;
    else if (en) t4_v_q <= b_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_xz_q[0] <= $signed(b_x[1]) * $signed(b_z[2]);
      t4_xz_q[1] <= $signed(b_x[2]) * $signed(b_z[1]);
      t4_xz_q[2] <= $signed(b_x[2]) * $signed(b_z[0]);
      t4_xz_q[3] <= $signed(b_x[0]) * $signed(b_z[2]);
      t4_xz_q[4] <= $signed(b_x[0]) * $signed(b_z[1]);
      t4_xz_q[5] <= $signed(b_x[1]) * $signed(b_z[0]);
      for (int k = 0; k < 3; k++) begin
        t4_xe_q[k] <= $signed(b_x[k]) * $signed(b_eye[k]);
        t4_ze_q[k] <= $signed(b_z[k]) * $signed(b_eye[k]);
      end
      t4_x_q   <= b_x;
      t4_z_q   <= b_z;
      t4_eye_q <= b_eye;
      t4_ok_q  <= !b_zero && !b_zero_fwd;
    end
  end

  // stage t5: y vector and the x and z dot products
  logic                    t5_v_q;
  logic [2:0][Y_W-1:0]     t5_y_q;
  logic signed [SUM_W-1:0] t5_dx_q;
  logic signed [SUM_W-1:0] t5_dz_q;
  logic [2:0][UNIT_W-1:0]  t5_x_q;
  logic [2:0][UNIT_W-1:0]  t5_z_q;
  logic [2:0][Q_W-1:0]     t5_eye_q;
  logic                    t5_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t5_v_q <= 1'b0;
    else if (en) t5_v_q <= t4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_y_q[0] <= Y_W'(round_q16(64'(t4_xz_q[0]) - 64'(t4_xz_q[1])));
      t5_y_q[1] <= Y_W'(round_q16(64'(t4_xz_q[2]) - 64'(t4_xz_q[3])));
      t5_y_q[2] <= Y_W'(round_q16(64'(t4_xz_q[4]) - 64'(t4_xz_q[5])));
      t5_dx_q   <= round_q16(64'(t4_xe_q[0]) + 64'(t4_xe_q[1]) + 64'(t4_xe_q[2]));
      t5_dz_q   <= round_q16(64'(t4_ze_q[0]) + 64'(t4_ze_q[1]) + 64'(t4_ze_q[2]));
      t5_x_q    <= t4_x_q;
      t5_z_q    <= t4_z_q;
      t5_eye_q  <= t4_eye_q;
      t5_ok_q   <= t4_ok_q;
    end
  end

  // stage t6: products of y with eye
  logic                          t6_v_q;
  logic signed [Y_W+Q_W-1:0]     t6_ye_q [3];
  logic [2:0][Y_W-1:0]           t6_y_q;
  logic signed [SUM_W-1:0]       t6_dx_q;
  logic signed [SUM_W-1:0]       t6_dz_q;
  logic [2:0][UNIT_W-1:0]        t6_x_q;
  logic [2:0][UNIT_W-1:0]        t6_z_q;
  logic                          t6_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t6_v_q <= 1'b0;
    else if (en) t6_v_q <= t5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t6_ye_q[k] <= $signed(t5_y_q[k]) * $signed(t5_eye_q[k]);
      end
      t6_y_q  <= t5_y_q;
      t6_dx_q <= t5_dx_q;
      t6_dz_q <= t5_dz_q;
      t6_x_q  <= t5_x_q;
      t6_z_q  <= t5_z_q;
      t6_ok_q <= t5_ok_q;
    end
  end

  // matrix assembly with saturation and degenerate zeroing
  logic signed [SUM_W-1:0]     dy;
  logic [3:0][3:0][Q_W-1:0]    mat_d;

  assign dy = round_q16(64'(t6_ye_q[0]) + 64'(t6_ye_q[1]) + 64'(t6_ye_q[2]));

  always_comb begin
    mat_d = '0;
    if (t6_ok_q) begin
      for (int r = 0; r < 3; r++) begin
        mat_d[r][0] = Q_W'($signed(t6_x_q[r]));
        mat_d[r][1] = Q_W'($signed(t6_y_q[r]));
        mat_d[r][2] = Q_W'(-$signed(t6_z_q[r]));
      end
      mat_d[3][0] = sat_q16(-t6_dx_q);
      mat_d[3][1] = sat_q16(-dy);
      mat_d[3][2] = sat_q16(t6_dz_q);
      mat_d[3][3] = Q_ONE;
    end
  end

  // row serializer
  logic                     busy_q;
  logic [1:0]               cnt_q;
  logic                     deg_q;
  logic [3:0][3:0][Q_W-1:0] mat_q;

  assign load = t6_v_q && (!busy_q || (out_o.ready && (cnt_q == ROW_LAST)));
  assign en   = !t6_v_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (busy_q && out_o.ready) begin
      if (cnt_q == ROW_LAST) busy_q <= 1'b0;
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= mat_d;
      deg_q <= !t6_ok_q;
    end
  end

  assign out_o.valid      = busy_q;
  assign out_o.row_index  = cnt_q;
  assign out_o.entry_col0 = mat_q[cnt_q][0];
  assign out_o.entry_col1 = mat_q[cnt_q][1];
  assign out_o.entry_col2 = mat_q[cnt_q][2];
  assign out_o.entry_col3 = mat_q[cnt_q][3];
  assign out_o.last_row   = (cnt_q == ROW_LAST);
  assign out_o.degenerate = deg_q;

  // rows step by one while the matrix drains
  `LAV_ASSERT_NEXT(a_row_step, busy_q && out_o.ready && (cnt_q != ROW_LAST), busy_q && (cnt_q == $past(cnt_q) + 2'd1), "row counter did not advance by one")
  // serializer goes idle after the last row when nothing waits behind it
  `LAV_ASSERT_NEXT(a_drain, busy_q && out_o.ready && (cnt_q == ROW_LAST) && !t6_v_q, !busy_q, "serializer stayed busy after last row")
  // a degenerate matrix carries zero entries on every row
  `LAV_ASSERT_IMPL(a_deg_zero, busy_q && deg_q, (out_o.entry_col0 == 32'd0) && (out_o.entry_col1 == 32'd0) && (out_o.entry_col2 == 32'd0) && (out_o.entry_col3 == 32'd0), "degenerate row has nonzero entry")
  // a valid matrix ends in one
  `LAV_ASSERT_IMPL(a_corner_one, busy_q && !deg_q, mat_q[3][3] == Q_ONE, "corner entry of valid matrix is not one")

endmodule
